// ----- rtl/boot_pkg.sv -----
// Shared definitions for the box overlap test pipeline.
// Holds the default coordinate width, register index codes and stage control type.
// No dependencies.
package boot_pkg;

  // Default width of every coordinate, signed Q8.8 at 16 bits
  localparam int unsigned CoordWidthDef = 16;

  // Configuration register file
  localparam int unsigned NumRegs = 6;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_e;

  // Dimensions and oriented-box axes
  localparam int unsigned NumDims = 3;
  localparam int unsigned NumAxes = 3;

  // Control that travels with an item once the box-axis test is settled
  typedef struct packed {
    logic valid;
    logic box_sep;
  } pipe_ctl_t;

endpackage

// ----- rtl/box_oriented_box_overlap_test.sv -----
// Four register stages from input transfer to result valid: three work stages
// plus the output register. Throughput: one box per cycle while the output is not
// stalled; each stage loads when empty or unloading, so a stalled output fills the pipe.
// Reset: asynchronous, active low; clears all stage valids, the output valid
// and the six query box registers to zero.
// Top level of the box overlap test; depends on boot_pkg, boot_prep, boot_prod, boot_sum.
module box_oriented_box_overlap_test #(
  parameter int unsigned COORD_WIDTH = boot_pkg::CoordWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [boot_pkg::RegIdxW-1:0]        cfg_index_i,
  input  logic [COORD_WIDTH-1:0]              cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]       center_x_i,
  input  logic signed [COORD_WIDTH-1:0]       center_y_i,
  input  logic signed [COORD_WIDTH-1:0]       center_z_i,
  input  logic signed [COORD_WIDTH-1:0]       axis_u_x_i,
  input  logic signed [COORD_WIDTH-1:0]       axis_u_y_i,
  input  logic signed [COORD_WIDTH-1:0]       axis_u_z_i,
  input  logic signed [COORD_WIDTH-1:0]       axis_v_x_i,
  input  logic signed [COORD_WIDTH-1:0]       axis_v_y_i,
  input  logic signed [COORD_WIDTH-1:0]       axis_v_z_i,
  input  logic signed [COORD_WIDTH-1:0]       axis_w_x_i,
  input  logic signed [COORD_WIDTH-1:0]       axis_w_y_i,
  input  logic signed [COORD_WIDTH-1:0]       axis_w_z_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                overlap_o,
  output logic                                box_axis_split_o
);
  import boot_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned SumW = 2 * W + 5;
  localparam int unsigned NumTerms = NumAxes * NumDims;

  // Query box registers
  logic signed [W-1:0] min_x_q, min_y_q, min_z_q;
  logic signed [W-1:0] max_x_q, max_y_q, max_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      min_y_q <= '0;
      min_z_q <= '0;
      max_x_q <= '0;
      max_y_q <= '0;
      max_z_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MIN_X: min_x_q <= cfg_data_i;
        REG_MIN_Y: min_y_q <= cfg_data_i;
        REG_MIN_Z: min_z_q <= cfg_data_i;
        REG_MAX_X: max_x_q <= cfg_data_i;
        REG_MAX_Y: max_y_q <= cfg_data_i;
        REG_MAX_Z: max_z_q <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Gather ports into arrays
  logic signed [W-1:0] box_min [NumDims];
  logic signed [W-1:0] box_max [NumDims];
  logic signed [W-1:0] center  [NumDims];
  logic signed [W-1:0] ax_in   [NumTerms];

  assign box_min = '{min_x_q, min_y_q, min_z_q};
  assign box_max = '{max_x_q, max_y_q, max_z_q};
  assign center  = '{center_x_i, center_y_i, center_z_i};
  assign ax_in   = '{axis_u_x_i, axis_u_y_i, axis_u_z_i,
                     axis_v_x_i, axis_v_y_i, axis_v_z_i,
                     axis_w_x_i, axis_w_y_i, axis_w_z_i};

  // Stage 1
  logic                s1_valid, s2_ready;
  logic signed [W-1:0] s1_ax      [NumTerms];
  logic signed [W:0]   s1_ext2    [NumDims];
  logic signed [W+1:0] s1_off2    [NumDims];
  logic signed [W+3:0] s1_box_lhs [NumDims];

  boot_prep #(.W(W)) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .box_min_i (box_min),
    .box_max_i (box_max),
    .center_i  (center),
    .ax_i      (ax_in),
    .valid_o   (s1_valid),
    .ready_i   (s2_ready),
    .ax_o      (s1_ax),
    .ext2_o    (s1_ext2),
    .off2_o    (s1_off2),
    .box_lhs_o (s1_box_lhs)
  );

  // Stage 2
  pipe_ctl_t             s2_ctl;
  logic                  s3_ready;
  logic signed [2*W+1:0] s2_pe [NumTerms];
  logic signed [2*W+1:0] s2_pl [NumTerms];
  logic signed [2*W+1:0] s2_pp [NumTerms];

  boot_prod #(.W(W)) u_prod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .ready_o   (s2_ready),
    .ax_i      (s1_ax),
    .ext2_i    (s1_ext2),
    .off2_i    (s1_off2),
    .box_lhs_i (s1_box_lhs),
    .ctl_o     (s2_ctl),
    .ready_i   (s3_ready),
    .pe_o      (s2_pe),
    .pl_o      (s2_pl),
    .pp_o      (s2_pp)
  );

  // Stage 3
  pipe_ctl_t              s3_ctl;
  logic                   out_stage_ready;
  logic signed [SumW-1:0] s3_lhs  [NumAxes];
  logic signed [SumW-1:0] s3_proj [NumAxes];

  boot_sum #(.W(W)) u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (s2_ctl),
    .ready_o (s3_ready),
    .pe_i    (s2_pe),
    .pl_i    (s2_pl),
    .pp_i    (s2_pp),
    .ctl_o   (s3_ctl),
    .ready_i (out_stage_ready),
    .lhs_o   (s3_lhs),
    .proj_o  (s3_proj)
  );

  // Oriented-axis compares and result encoding
  logic obb_sep;
  logic overlap_d, split_d;

  always_comb begin
    logic signed [SumW-1:0] proj_abs;
    obb_sep = 1'b0;
    for (int a = 0; a < NumAxes; a++) begin
      proj_abs = s3_proj[a][SumW-1] ? -s3_proj[a] : s3_proj[a];
      if (s3_lhs[a] < proj_abs) begin
        obb_sep = 1'b1;
      end
    end
    overlap_d = !(s3_ctl.box_sep || obb_sep);
    split_d   = s3_ctl.box_sep;
  end

  // Output register
  logic out_valid_q, overlap_q, split_q;

  assign out_stage_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_stage_ready) begin
      out_valid_q <= s3_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ctl.valid && out_stage_ready) begin
      overlap_q <= overlap_d;
      split_q   <= split_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign overlap_o        = overlap_q;
  assign box_axis_split_o = split_q;

endmodule

// ----- rtl/boot_prep.sv -----
// Stage 1: doubled half sizes, doubled centre offsets and box-axis extent sums.
// Depends on boot_pkg.
module boot_prep #(
  parameter int unsigned W = boot_pkg::CoordWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic signed [W-1:0] box_min_i [boot_pkg::NumDims],
  input  logic signed [W-1:0] box_max_i [boot_pkg::NumDims],
  input  logic signed [W-1:0] center_i  [boot_pkg::NumDims],
  input  logic signed [W-1:0] ax_i      [boot_pkg::NumAxes*boot_pkg::NumDims],
  output logic                valid_o,
  input  logic                ready_i,
  output logic signed [W-1:0] ax_o      [boot_pkg::NumAxes*boot_pkg::NumDims],
  output logic signed [W:0]   ext2_o    [boot_pkg::NumDims],
  output logic signed [W+1:0] off2_o    [boot_pkg::NumDims],
  output logic signed [W+3:0] box_lhs_o [boot_pkg::NumDims]
);
  import boot_pkg::*;

  localparam int unsigned ExtW = W + 1;
  localparam int unsigned OffW = W + 2;
  localparam int unsigned BoxW = W + 4;

  logic                   valid_q;
  logic signed [W-1:0]    ax_q      [NumAxes*NumDims];
  logic signed [ExtW-1:0] ext2_d    [NumDims];
  logic signed [ExtW-1:0] ext2_q    [NumDims];
  logic signed [OffW-1:0] off2_d    [NumDims];
  logic signed [OffW-1:0] off2_q    [NumDims];
  logic signed [BoxW-1:0] box_lhs_d [NumDims];
  logic signed [BoxW-1:0] box_lhs_q [NumDims];

  assign ready_o = !valid_q || ready_i;

  // Per dimension: (max - min), (2c - min - max), 2*sum|axis comp| + (max - min)
  always_comb begin
    logic signed [OffW-1:0] lo_e;
    logic signed [OffW-1:0] hi_e;
    logic signed [OffW-1:0] c_e;
    logic        [W-1:0]    mag;
    logic signed [BoxW-1:0] msum;
    for (int k = 0; k < NumDims; k++) begin
      lo_e = OffW'(box_min_i[k]);
      hi_e = OffW'(box_max_i[k]);
      c_e  = OffW'(center_i[k]);
      ext2_d[k] = ExtW'(hi_e - lo_e);
      off2_d[k] = (c_e <<< 1) - lo_e - hi_e;
      msum = '0;
      for (int a = 0; a < NumAxes; a++) begin
        // magnitude of the most negative value still fits W unsigned bits
        mag  = ax_i[a*NumDims+k][W-1] ? W'(-ax_i[a*NumDims+k]) : W'(ax_i[a*NumDims+k]);
        msum = msum + $signed(BoxW'(mag));
      end
      box_lhs_d[k] = (msum <<< 1) + BoxW'(ext2_d[k]);
    end
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ax_q      <= ax_i;
      ext2_q    <= ext2_d;
      off2_q    <= off2_d;
      box_lhs_q <= box_lhs_d;
    end
  end

  assign valid_o   = valid_q;
  assign ax_o      = ax_q;
  assign ext2_o    = ext2_q;
  assign off2_o    = off2_q;
  assign box_lhs_o = box_lhs_q;

endmodule

// ----- rtl/boot_prod.sv -----
// Stage 2: box-axis compares and the 27 products for the oriented-box axes.
// Depends on boot_pkg.
module boot_prod #(
  parameter int unsigned W = boot_pkg::CoordWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [W-1:0]  ax_i      [boot_pkg::NumAxes*boot_pkg::NumDims],
  input  logic signed [W:0]    ext2_i    [boot_pkg::NumDims],
  input  logic signed [W+1:0]  off2_i    [boot_pkg::NumDims],
  input  logic signed [W+3:0]  box_lhs_i [boot_pkg::NumDims],
  output boot_pkg::pipe_ctl_t  ctl_o,
  input  logic                 ready_i,
  output logic signed [2*W+1:0] pe_o     [boot_pkg::NumAxes*boot_pkg::NumDims],
  output logic signed [2*W+1:0] pl_o     [boot_pkg::NumAxes*boot_pkg::NumDims],
  output logic signed [2*W+1:0] pp_o     [boot_pkg::NumAxes*boot_pkg::NumDims]
);
  import boot_pkg::*;

  localparam int unsigned BoxW = W + 4;
  localparam int unsigned PrdW = 2 * W + 2;
  localparam int unsigned NumTerms = NumAxes * NumDims;

  pipe_ctl_t              ctl_q;
  logic                   box_sep_d;
  logic signed [PrdW-1:0] pe_d [NumTerms];
  logic signed [PrdW-1:0] pl_d [NumTerms];
  logic signed [PrdW-1:0] pp_d [NumTerms];
  logic signed [PrdW-1:0] pe_q [NumTerms];
  logic signed [PrdW-1:0] pl_q [NumTerms];
  logic signed [PrdW-1:0] pp_q [NumTerms];

  assign ready_o = !ctl_q.valid || ready_i;

  // A box axis separates when its extent sum is below the centre offset magnitude
  always_comb begin
    logic signed [BoxW-1:0] off_e;
    logic signed [BoxW-1:0] off_abs;
    box_sep_d = 1'b0;
    for (int k = 0; k < NumDims; k++) begin
      off_e   = BoxW'(off2_i[k]);
      off_abs = off_e[BoxW-1] ? -off_e : off_e;
      if (box_lhs_i[k] < off_abs) begin
        box_sep_d = 1'b1;
      end
    end
  end

  // Axis times half size, axis squared, axis times offset
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      for (int k = 0; k < NumDims; k++) begin
        pe_d[a*NumDims+k] = PrdW'(ax_i[a*NumDims+k]) * PrdW'(ext2_i[k]);
        pl_d[a*NumDims+k] = PrdW'(ax_i[a*NumDims+k]) * PrdW'(ax_i[a*NumDims+k]);
        pp_d[a*NumDims+k] = PrdW'(ax_i[a*NumDims+k]) * PrdW'(off2_i[k]);
      end
    end
  end

  // Stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready_o) begin
      ctl_q.valid   <= valid_i;
      ctl_q.box_sep <= box_sep_d;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pe_q <= pe_d;
      pl_q <= pl_d;
      pp_q <= pp_d;
    end
  end

  assign ctl_o = ctl_q;
  assign pe_o  = pe_q;
  assign pl_o  = pl_q;
  assign pp_o  = pp_q;

endmodule

// ----- rtl/boot_sum.sv -----
// Stage 3: per oriented axis, projected radius sum and offset projection.
// Depends on boot_pkg.
module boot_sum #(
  parameter int unsigned W = boot_pkg::CoordWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  boot_pkg::pipe_ctl_t   ctl_i,
  output logic                  ready_o,
  input  logic signed [2*W+1:0] pe_i   [boot_pkg::NumAxes*boot_pkg::NumDims],
  input  logic signed [2*W+1:0] pl_i   [boot_pkg::NumAxes*boot_pkg::NumDims],
  input  logic signed [2*W+1:0] pp_i   [boot_pkg::NumAxes*boot_pkg::NumDims],
  output boot_pkg::pipe_ctl_t   ctl_o,
  input  logic                  ready_i,
  output logic signed [2*W+4:0] lhs_o  [boot_pkg::NumAxes],
  output logic signed [2*W+4:0] proj_o [boot_pkg::NumAxes]
);
  import boot_pkg::*;

  localparam int unsigned SumW = 2 * W + 5;

  pipe_ctl_t              ctl_q;
  logic signed [SumW-1:0] lhs_d  [NumAxes];
  logic signed [SumW-1:0] proj_d [NumAxes];
  logic signed [SumW-1:0] lhs_q  [NumAxes];
  logic signed [SumW-1:0] proj_q [NumAxes];

  assign ready_o = !ctl_q.valid || ready_i;

  // lhs = sum|axis*size| + 2*len^2, proj = sum axis*offset
  always_comb begin
    logic signed [SumW-1:0] pe_e;
    logic signed [SumW-1:0] abs_sum;
    logic signed [SumW-1:0] len2;
    logic signed [SumW-1:0] dot;
    for (int a = 0; a < NumAxes; a++) begin
      abs_sum = '0;
      len2    = '0;
      dot     = '0;
      for (int k = 0; k < NumDims; k++) begin
        pe_e    = SumW'(pe_i[a*NumDims+k]);
        abs_sum = abs_sum + (pe_e[SumW-1] ? -pe_e : pe_e);
        len2    = len2 + SumW'(pl_i[a*NumDims+k]);
        dot     = dot + SumW'(pp_i[a*NumDims+k]);
      end
      lhs_d[a]  = abs_sum + (len2 <<< 1);
      proj_d[a] = dot;
    end
  end

  // Stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready_o) begin
      ctl_q <= ctl_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.valid && ready_o) begin
      lhs_q  <= lhs_d;
      proj_q <= proj_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign lhs_o  = lhs_q;
  assign proj_o = proj_q;

endmodule

// ----- rtl/boot_checker.sv -----
// Port-level checks for the box overlap test, bound to the top level.
// Depends on boot_pkg and box_oriented_box_overlap_test.
module boot_checker #(
  parameter int unsigned COORD_WIDTH = boot_pkg::CoordWidthDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [boot_pkg::RegIdxW-1:0] cfg_index_i,
  input logic [COORD_WIDTH-1:0]       cfg_data_i,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         overlap_o,
  input logic                         box_axis_split_o
);
  import boot_pkg::*;

  // A held result keeps its value until the transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(overlap_o)
      && $stable(box_axis_split_o))
    else $error("result changed while stalled");

  // Overlap and a box-axis split exclude each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(overlap_o && box_axis_split_o))
    else $error("overlap reported together with box-axis split");

  // An empty output register means nothing upstream can be blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output is empty");

  // Configuration writes are never back-pressured
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

  // A configuration write carries a known index and value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> !$isunknown({cfg_index_i, cfg_data_i}))
    else $error("configuration write with unknown index or data");

endmodule

bind box_oriented_box_overlap_test boot_checker #(.COORD_WIDTH(COORD_WIDTH)) u_boot_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_valid_i      (cfg_valid_i),
  .cfg_ready_o      (cfg_ready_o),
  .cfg_index_i      (cfg_index_i),
  .cfg_data_i       (cfg_data_i),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .overlap_o        (overlap_o),
  .box_axis_split_o (box_axis_split_o)
);

// ----- test/tb_box_oriented_box_overlap_test.sv -----
// Self-checking testbench for the oriented-box versus query-box overlap test.
// Directed table, then random boxes under several query box settings, checked
// against an in-bench predictor. Depends on boot_pkg and box_oriented_box_overlap_test.
`timescale 1ns / 1ps

module tb_box_oriented_box_overlap_test;
  import boot_pkg::*;

  localparam int unsigned CW = CoordWidthDef;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int WATCHDOG = 3000;
  localparam logic [RegIdxW-1:0] IDX_SPARE_LO = RegIdxW'(NumRegs);
  localparam logic [RegIdxW-1:0] IDX_SPARE_HI = '1;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t cx, cy, cz;
    coord_t ux, uy, uz;
    coord_t vx, vy, vz;
    coord_t wx, wy, wz;
  } obox_t;

  typedef struct packed {
    logic overlap;
    logic split;
  } verdict_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PREDICT,
    ROW_KNOWN
  } row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic [RegIdxW-1:0] idx;
    coord_t val;
    obox_t box;
    verdict_t verdict;
  } stim_row_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // DUT stimulus
  logic cfg_valid_i = 1'b0;
  logic [RegIdxW-1:0] cfg_index_i = '0;
  coord_t cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  obox_t drive_box = '0;
  logic drive_known = 1'b0;
  verdict_t known_verdict = '0;

  logic cfg_ready_o, in_ready_o, out_valid_o, overlap_o, box_axis_split_o;

  // bench state
  coord_t query_bound [NumRegs] = '{default: '0};
  verdict_t pending_verdicts [$];
  verdict_t want;
  stim_row_t directed_rows [$];
  int errors = 0;
  int quiet_cycles = 0;
  logic gap_on = 1'b1;
  logic stall_on = 1'b1;

  box_oriented_box_overlap_test dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .center_x_i      (drive_box.cx),
    .center_y_i      (drive_box.cy),
    .center_z_i      (drive_box.cz),
    .axis_u_x_i      (drive_box.ux),
    .axis_u_y_i      (drive_box.uy),
    .axis_u_z_i      (drive_box.uz),
    .axis_v_x_i      (drive_box.vx),
    .axis_v_y_i      (drive_box.vy),
    .axis_v_z_i      (drive_box.vz),
    .axis_w_x_i      (drive_box.wx),
    .axis_w_y_i      (drive_box.wy),
    .axis_w_z_i      (drive_box.wz),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .overlap_o       (overlap_o),
    .box_axis_split_o(box_axis_split_o)
  );

  function automatic longint mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Separating axis test with both sides doubled; 64 bits hold every term exactly
  function automatic verdict_t judge_box(obox_t b);
    longint ctr [3];
    longint ax [3][3];
    longint ext2 [3];
    longint off2 [3];
    longint lo, hi, span, prod_sum, len2, proj;
    logic box_sep, obb_sep;
    verdict_t v;
    ctr = '{b.cx, b.cy, b.cz};
    ax[0] = '{b.ux, b.uy, b.uz};
    ax[1] = '{b.vx, b.vy, b.vz};
    ax[2] = '{b.wx, b.wy, b.wz};
    box_sep = 1'b0;
    obb_sep = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lo = query_bound[int'(REG_MIN_X) + k];
      hi = query_bound[int'(REG_MAX_X) + k];
      ext2[k] = hi - lo;
      off2[k] = 2 * ctr[k] - lo - hi;
    end
    // query box axes
    for (int k = 0; k < 3; k++) begin
      span = 2 * (mag(ax[0][k]) + mag(ax[1][k]) + mag(ax[2][k])) + ext2[k];
      if (span < mag(off2[k])) box_sep = 1'b1;
    end
    // oriented box axes, only when no query axis separated
    if (!box_sep) begin
      for (int a = 0; a < 3; a++) begin
        prod_sum = 0;
        len2 = 0;
        proj = 0;
        for (int k = 0; k < 3; k++) begin
          prod_sum += mag(ax[a][k] * ext2[k]);
          len2 += ax[a][k] * ax[a][k];
          proj += ax[a][k] * off2[k];
        end
        if (prod_sum + 2 * len2 < mag(proj)) obb_sep = 1'b1;
      end
    end
    v.overlap = !(box_sep || obb_sep);
    v.split = box_sep;
    return v;
  endfunction

  function automatic stim_row_t mk_write(logic [RegIdxW-1:0] idx, int val);
    stim_row_t r;
    r = '{kind: ROW_WRITE, idx: idx, val: coord_t'(val), box: '0, verdict: '0};
    return r;
  endfunction

  function automatic stim_row_t mk_predict(obox_t b);
    stim_row_t r;
    r = '{kind: ROW_PREDICT, idx: '0, val: '0, box: b, verdict: '0};
    return r;
  endfunction

  function automatic stim_row_t mk_known(obox_t b, logic ov, logic sp);
    stim_row_t r;
    r = '{kind: ROW_KNOWN, idx: '0, val: '0, box: b, verdict: '{ov, sp}};
    return r;
  endfunction

  function automatic int rand_coord(int sh);
    return int'($urandom_range(0, (2 << sh) - 1)) - (1 << sh);
  endfunction

  // Mostly boxes scattered around the query box, some pure noise
  function automatic obox_t rand_box();
    coord_t ctr [3];
    coord_t ax [9];
    int shc, sha, mid, zap;
    obox_t b;
    if ($urandom_range(0, 9) < 2) begin
      b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      shc = $urandom_range(2, 15);
      sha = $urandom_range(0, 14);
      for (int k = 0; k < 3; k++) begin
        mid = (int'(query_bound[int'(REG_MIN_X) + k]) +
               int'(query_bound[int'(REG_MAX_X) + k])) >>> 1;
        ctr[k] = coord_t'(mid + rand_coord(shc));
      end
      for (int j = 0; j < 9; j++) ax[j] = coord_t'(rand_coord(sha));
      // now and then flatten one half-extent vector to zero
      if ($urandom_range(0, 7) == 0) begin
        zap = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) ax[3 * zap + k] = '0;
      end
      b = '{ctr[0], ctr[1], ctr[2], ax[0], ax[1], ax[2],
            ax[3], ax[4], ax[5], ax[6], ax[7], ax[8]};
    end
    return b;
  endfunction

  // Transfer monitor: shadow registers, expectations, result check, watchdog count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < NumRegs)
        query_bound[cfg_index_i] = cfg_data_i;
      if (in_valid_i && in_ready_o)
        pending_verdicts.push_back(drive_known ? known_verdict : judge_box(drive_box));
      if (out_valid_o && out_ready_i) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result, overlap %0b split %0b",
                   $time, overlap_o, box_axis_split_o);
          errors++;
        end else begin
          want = pending_verdicts.pop_front();
          if (overlap_o !== want.overlap) begin
            $display("%0t: overlap expected %0b got %0b", $time, want.overlap, overlap_o);
            errors++;
          end
          if (box_axis_split_o !== want.split) begin
            $display("%0t: box_axis_split expected %0b got %0b",
                     $time, want.split, box_axis_split_o);
            errors++;
          end
        end
      end
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG);
    $display("[box_oriented_box_overlap_test] ERROR");
    $finish;
  end

  // Result side: ready stalls in random bursts while stall_on
  always begin
    @(negedge clk_i);
    if (stall_on && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  // Called at a falling edge, returns at a later falling edge with nothing pending
  task automatic wait_drained();
    do @(negedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  // Caller lowers cfg_valid_i after the last write of a batch
  task automatic write_reg(logic [RegIdxW-1:0] idx, coord_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_box(obox_t b, logic known, verdict_t v);
    if (gap_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    drive_box <= b;
    drive_known <= known;
    known_verdict <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Rewrite the whole query box once the pipe is empty; spare indexes get junk
  task automatic program_query(coord_t lo [3], coord_t hi [3]);
    in_valid_i <= 1'b0;
    wait_drained();
    write_reg(IDX_SPARE_LO, coord_t'($urandom));
    write_reg(REG_MIN_X, lo[0]);
    write_reg(REG_MIN_Y, lo[1]);
    write_reg(REG_MIN_Z, lo[2]);
    write_reg(REG_MAX_X, hi[0]);
    write_reg(REG_MAX_Y, hi[1]);
    write_reg(REG_MAX_Z, hi[2]);
    write_reg(IDX_SPARE_HI, coord_t'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_directed();
    // reset query box: a single point at the origin
    directed_rows.push_back(mk_known('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b0));
    directed_rows.push_back(mk_known('{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 1'b1));
    directed_rows.push_back(mk_known('{-32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 1'b1));
    directed_rows.push_back(mk_known('{0, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 1'b1));
    directed_rows.push_back(mk_known('{0, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 1'b1));
    directed_rows.push_back(mk_known('{0, 0, 0, -32768, -32768, -32768, -32768, -32768,
                                       -32768, -32768, -32768, -32768}, 1'b1, 1'b0));
    directed_rows.push_back(mk_predict('{-32768, -32768, -32768, 32767, 32767, 32767,
                                         32767, 32767, 32767, 32767, 32767, 32767}));
    directed_rows.push_back(mk_predict('{32767, 32767, 32767, 32767, 32767, 32767,
                                         32767, 32767, 32767, 32767, 32767, 32767}));
    directed_rows.push_back(mk_predict('{32767, 32767, 32767, -32768, 0, 0,
                                         0, -32768, 0, 0, 0, -32768}));
    // unit cube, spare indexes must not land anywhere
    directed_rows.push_back(mk_write(REG_MIN_X, -256));
    directed_rows.push_back(mk_write(REG_MIN_Y, -256));
    directed_rows.push_back(mk_write(REG_MIN_Z, -256));
    directed_rows.push_back(mk_write(REG_MAX_X, 256));
    directed_rows.push_back(mk_write(REG_MAX_Y, 256));
    directed_rows.push_back(mk_write(REG_MAX_Z, 256));
    directed_rows.push_back(mk_write(IDX_SPARE_LO, 16'h5a5a));
    directed_rows.push_back(mk_write(IDX_SPARE_HI, -1));
    directed_rows.push_back(mk_known('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b0));
    directed_rows.push_back(mk_known('{32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 1'b1));
    directed_rows.push_back(mk_predict('{400, 400, 0, 100, -100, 0, 100, 100, 0, 0, 0, 100}));
    directed_rows.push_back(mk_predict('{600, -600, 300, 200, 200, 0, -200, 200, 0,
                                         0, 0, 50}));
    // inverted bounds: negative span is used as is
    directed_rows.push_back(mk_write(REG_MIN_X, 256));
    directed_rows.push_back(mk_write(REG_MIN_Y, 256));
    directed_rows.push_back(mk_write(REG_MIN_Z, 256));
    directed_rows.push_back(mk_write(REG_MAX_X, -256));
    directed_rows.push_back(mk_write(REG_MAX_Y, -256));
    directed_rows.push_back(mk_write(REG_MAX_Z, -256));
    directed_rows.push_back(mk_known('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 1'b1));
    directed_rows.push_back(mk_known('{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256}, 1'b1, 1'b0));
    // widest query box: centre at either end just touches
    directed_rows.push_back(mk_write(REG_MIN_X, -32768));
    directed_rows.push_back(mk_write(REG_MIN_Y, -32768));
    directed_rows.push_back(mk_write(REG_MIN_Z, -32768));
    directed_rows.push_back(mk_write(REG_MAX_X, 32767));
    directed_rows.push_back(mk_write(REG_MAX_Y, 32767));
    directed_rows.push_back(mk_write(REG_MAX_Z, 32767));
    directed_rows.push_back(mk_known('{-32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0},
                                     1'b1, 1'b0));
    directed_rows.push_back(mk_known('{32767, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0},
                                     1'b1, 1'b0));
    directed_rows.push_back(mk_predict('{32767, 32767, 32767, -32768, -32768, -32768,
                                         -32768, -32768, -32768, -32768, -32768, -32768}));
    directed_rows.push_back(mk_predict('{-1, 0, 1, 32767, -32768, 1, -1, 256, -256,
                                         12345, -12345, 0}));
  endtask

  initial begin
    stim_row_t row;
    logic in_cfg;
    coord_t lo [3];
    coord_t hi [3];
    int base;

    in_cfg = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    load_directed();
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (!in_cfg) begin
          in_valid_i <= 1'b0;
          wait_drained();
          in_cfg = 1'b1;
        end
        write_reg(row.idx, row.val);
      end else begin
        if (in_cfg) begin
          cfg_valid_i <= 1'b0;
          in_cfg = 1'b0;
        end
        send_box(row.box, row.kind == ROW_KNOWN, row.verdict);
      end
    end

    // random phases, each under its own query box
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      for (int k = 0; k < 3; k++) begin
        case (phase)
          0: begin
            base = rand_coord(10);
            lo[k] = coord_t'(base);
            hi[k] = coord_t'(base + int'($urandom_range(0, 2048)));
          end
          1: begin
            lo[k] = coord_t'(-32768);
            hi[k] = coord_t'(32767);
          end
          2: begin
            base = rand_coord(12);
            hi[k] = coord_t'(base);
            lo[k] = coord_t'(base + int'($urandom_range(1, 1024)));
          end
          3: begin
            lo[k] = coord_t'(rand_coord(12));
            hi[k] = lo[k];
          end
          4: begin
            lo[k] = coord_t'(32767);
            hi[k] = coord_t'(32767);
          end
          5: begin
            lo[k] = coord_t'(-32768);
            hi[k] = coord_t'(-32768);
          end
          default: begin
            lo[k] = coord_t'($urandom);
            hi[k] = coord_t'($urandom);
          end
        endcase
      end
      program_query(lo, hi);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // idle pattern changes every few dozen boxes; none in the closing phase
        if (n % 40 == 0) begin
          gap_on = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
          stall_on <= (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        // hold the sender until the pipe has emptied
        if (n == PHASE_ITEMS / 2) begin
          in_valid_i <= 1'b0;
          wait_drained();
        end
        send_box(rand_box(), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (8) @(negedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[box_oriented_box_overlap_test] OK");
    end else begin
      $display("[box_oriented_box_overlap_test] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/boot_pkg.sv
rtl/boot_prep.sv
rtl/boot_prod.sv
rtl/boot_sum.sv
rtl/box_oriented_box_overlap_test.sv
rtl/boot_checker.sv
test/tb_box_oriented_box_overlap_test.sv
